@@ src/lif_pkg.sv @@
package lif_pkg;

   localparam int IDX_W       = 5;
   localparam int DATA_W      = 32;
   localparam int K_W         = 16;
   localparam int PROD_W      = DATA_W + K_W;
   localparam int CSR_IDX_W   = 2;
   localparam int REQ_W       = 40;
   localparam int RSP_W       = 72;
   localparam int PIPE_STAGES = 5;

   localparam int NEURON_COUNT_DEF = 32;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_VOLTAGE_DECAY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PSP_GAIN      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PSP_DECAY     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RESET_VOLTAGE = 2'd3;

   localparam logic signed [K_W-1:0]    VOLTAGE_DECAY_RST = -16'sd652;
   localparam logic signed [K_W-1:0]    PSP_GAIN_RST      = 16'sd16384;
   localparam logic signed [K_W-1:0]    PSP_DECAY_RST     = -16'sd3196;
   localparam logic signed [DATA_W-1:0] RESET_VOLTAGE_RST = -32'sd1686367527;

   localparam logic [DATA_W-1:0] PSP_RST          = 32'h0000_0000;
   localparam logic [DATA_W-1:0] VOLT_RST         = 32'hFFFF_FFFF;
   localparam logic [DATA_W:0]   DRIFT            = 33'h0100_0000;
   localparam logic [DATA_W-1:0] REFRACTORY_TICKS = 32'd20;

   typedef struct packed {
      logic signed [K_W-1:0]    voltage_decay;
      logic signed [K_W-1:0]    psp_gain;
      logic signed [K_W-1:0]    psp_decay;
      logic signed [DATA_W-1:0] reset_voltage;
   } cfg_type;

   // what the hazard check sees of one stage
   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
   } stage_tag_type;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  idx;
      logic [DATA_W-1:0] psp;
      logic [DATA_W-1:0] volt;
   } wb_type;

endpackage

@@ src/lif_ram.sv @@
module lif_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ src/lif_pipe.sv @@
module lif_pipe (
   input  logic                                    clock,
   input  logic                                    reset,
   input  lif_pkg::cfg_type                        cfg,
   input  logic                                    in_valid,
   input  logic [lif_pkg::IDX_W-1:0]               in_idx,
   input  logic                                    in_bank,
   input  logic [lif_pkg::DATA_W-1:0]              in_cur,
   output logic                                    in_ready,
   input  logic [lif_pkg::DATA_W-1:0]              old_psp,
   input  logic [lif_pkg::DATA_W-1:0]              old_volt,
   output lif_pkg::stage_tag_type [lif_pkg::PIPE_STAGES-1:0] tags,
   output lif_pkg::wb_type                         wb,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [lif_pkg::IDX_W-1:0]               rsp_idx,
   output logic                                    rsp_spiked,
   output logic [lif_pkg::DATA_W-1:0]              rsp_psp,
   output logic [lif_pkg::DATA_W-1:0]              rsp_volt
);

   localparam int DW = lif_pkg::DATA_W;
   localparam int IW = lif_pkg::IDX_W;
   localparam int PW = lif_pkg::PROD_W;
   localparam int KW = lif_pkg::K_W;

   logic ld1, ld2, ld3, ld4, ld5, ld_out;

   // stage 1: index, current; stored state arrives from the ram
   logic          vld1_ff;
   logic [IW-1:0] idx1_ff;
   logic          bank1_ff;
   logic [DW-1:0] cur1_ff;

   // stage 2: s = input + psp
   logic          vld2_ff;
   logic [IW-1:0] idx2_ff;
   logic          bank2_ff;
   logic [DW-1:0] sum2_ff, sum2_in;
   logic [DW-1:0] volt2_ff;

   // stage 3: decay products
   logic          vld3_ff;
   logic [IW-1:0] idx3_ff;
   logic          bank3_ff;
   logic [DW-1:0] sum3_ff;
   logic [DW-1:0] volt3_ff;
   logic [DW-1:0] pdec3_ff, pdec3_in;
   logic [DW-1:0] vdec3_ff, vdec3_in;
   logic signed [PW-1:0] pdec_prod, vdec_prod;

   // stage 4: new psp, leaked voltage
   logic          vld4_ff;
   logic [IW-1:0] idx4_ff;
   logic          bank4_ff;
   logic [DW-1:0] psp4_ff, psp4_in;
   logic [DW-1:0] volt4_ff;
   logic [DW-1:0] vlin4_ff, vlin4_in;

   // stage 5: gain product
   logic          vld5_ff;
   logic [IW-1:0] idx5_ff;
   logic          bank5_ff;
   logic [DW-1:0] psp5_ff;
   logic [DW-1:0] volt5_ff;
   logic [DW-1:0] vlin5_ff;
   logic [DW-1:0] gain5_ff, gain5_in;
   logic signed [PW-1:0] gain_prod;

   // output register
   logic          rsp_vld_ff;
   logic [IW-1:0] rsp_idx_ff;
   logic          rsp_spk_ff, rsp_spk_in;
   logic [DW-1:0] rsp_psp_ff, rsp_psp_in;
   logic [DW-1:0] rsp_volt_ff, rsp_volt_in;

   logic [DW-1:0] vn;
   logic [DW:0]   drifted;
   logic          spike;
   logic [DW-1:0] nv;

   // a stage takes new content when empty or when it empties this cycle
   assign ld_out   = !rsp_vld_ff || rsp_ready;
   assign ld5      = !vld5_ff || ld_out;
   assign ld4      = !vld4_ff || ld5;
   assign ld3      = !vld3_ff || ld4;
   assign ld2      = !vld2_ff || ld3;
   assign ld1      = !vld1_ff || ld2;
   assign in_ready = ld1;

   assign sum2_in   = cur1_ff + old_psp;
   assign pdec_prod = $signed(sum2_ff) * cfg.psp_decay;
   assign vdec_prod = $signed(volt2_ff) * cfg.voltage_decay;
   assign pdec3_in  = pdec_prod[PW-1:KW];
   assign vdec3_in  = vdec_prod[PW-1:KW];
   assign psp4_in   = sum3_ff + pdec3_ff;
   assign vlin4_in  = volt3_ff + vdec3_ff;
   assign gain_prod = $signed(psp4_ff) * cfg.psp_gain;
   assign gain5_in  = gain_prod[PW-1:KW];

   // mode decision on the old voltage
   assign vn      = vlin5_ff + gain5_ff;
   assign drifted = {vn[DW-1], vn} - lif_pkg::DRIFT;
   assign spike   = volt5_ff[DW-1] && !drifted[DW];

   always_comb begin
      if (volt5_ff[DW-1]) begin
         nv = spike ? lif_pkg::REFRACTORY_TICKS : drifted[DW-1:0];
      end else if (volt5_ff == '0) begin
         nv = cfg.reset_voltage;
      end else begin
         nv = volt5_ff - DW'(1);
      end
   end

   // outside the bank: echo index, zero payload
   assign rsp_spk_in  = bank5_ff && spike;
   assign rsp_psp_in  = bank5_ff ? psp5_ff : '0;
   assign rsp_volt_in = bank5_ff ? nv : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff    <= 1'b0;
         vld2_ff    <= 1'b0;
         vld3_ff    <= 1'b0;
         vld4_ff    <= 1'b0;
         vld5_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (ld1) vld1_ff <= in_valid;
         if (ld2) vld2_ff <= vld1_ff;
         if (ld3) vld3_ff <= vld2_ff;
         if (ld4) vld4_ff <= vld3_ff;
         if (ld5) vld5_ff <= vld4_ff;
         if (ld_out) rsp_vld_ff <= vld5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         idx1_ff  <= in_idx;
         bank1_ff <= in_bank;
         cur1_ff  <= in_cur;
      end
      if (ld2) begin
         idx2_ff  <= idx1_ff;
         bank2_ff <= bank1_ff;
         sum2_ff  <= sum2_in;
         volt2_ff <= old_volt;
      end
      if (ld3) begin
         idx3_ff  <= idx2_ff;
         bank3_ff <= bank2_ff;
         sum3_ff  <= sum2_ff;
         volt3_ff <= volt2_ff;
         pdec3_ff <= pdec3_in;
         vdec3_ff <= vdec3_in;
      end
      if (ld4) begin
         idx4_ff  <= idx3_ff;
         bank4_ff <= bank3_ff;
         psp4_ff  <= psp4_in;
         volt4_ff <= volt3_ff;
         vlin4_ff <= vlin4_in;
      end
      if (ld5) begin
         idx5_ff  <= idx4_ff;
         bank5_ff <= bank4_ff;
         psp5_ff  <= psp4_ff;
         volt5_ff <= volt4_ff;
         vlin5_ff <= vlin4_ff;
         gain5_ff <= gain5_in;
      end
      if (ld_out) begin
         rsp_idx_ff  <= idx5_ff;
         rsp_spk_ff  <= rsp_spk_in;
         rsp_psp_ff  <= rsp_psp_in;
         rsp_volt_ff <= rsp_volt_in;
      end
   end

   assign tags[0] = '{valid: vld1_ff, idx: idx1_ff};
   assign tags[1] = '{valid: vld2_ff, idx: idx2_ff};
   assign tags[2] = '{valid: vld3_ff, idx: idx3_ff};
   assign tags[3] = '{valid: vld4_ff, idx: idx4_ff};
   assign tags[4] = '{valid: vld5_ff, idx: idx5_ff};

   // state is written as the item leaves for the output register
   assign wb.en   = vld5_ff && ld_out && bank5_ff;
   assign wb.idx  = idx5_ff;
   assign wb.psp  = psp5_ff;
   assign wb.volt = nv;

   assign rsp_valid  = rsp_vld_ff;
   assign rsp_idx    = rsp_idx_ff;
   assign rsp_spiked = rsp_spk_ff;
   assign rsp_psp    = rsp_psp_ff;
   assign rsp_volt   = rsp_volt_ff;

endmodule

@@ src/lif_neuron_update.sv @@
// channel | dir | handshake             | payload
// req     | in  | req_tvalid/req_tready | tdata: neuron_index, input_current
// rsp     | out | rsp_tvalid/rsp_tready | tdata: out_index, spiked, new_psp, new_voltage
// csr     | in  | csr_we                | csr_index, csr_wdata
//
// From req to rsp: stored-state read, add, two decay multiplies,
// psp add, gain multiply, then the voltage add, drift and write-back.
// One transaction per cycle while neurons differ and rsp is not stalled; a
// neuron already in flight holds req until its earlier update is written
// back, since the voltage update passes through two multipliers.
// Synchronous reset clears control and per-entry valid bits and loads the
// config registers with reset values; no clearing pass. rsp back-pressure
// first fills pipeline bubbles, then drops req_tready.
module lif_neuron_update #(
   parameter int NEURON_COUNT = lif_pkg::NEURON_COUNT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [4:0] neuron_index, [36:5] input_current
   input  logic [lif_pkg::REQ_W-1:0]        req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [4:0] out_index, [5] spiked, [37:6] new_psp, [69:38] new_voltage
   output logic [lif_pkg::RSP_W-1:0]        rsp_tdata,
   input  logic                             csr_we,
   input  logic [lif_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lif_pkg::DATA_W-1:0]       csr_wdata
);

   localparam int DW        = lif_pkg::DATA_W;
   localparam int IW        = lif_pkg::IDX_W;
   localparam int KW        = lif_pkg::K_W;
   localparam int MEM_DEPTH = NEURON_COUNT < (1 << IW) ? NEURON_COUNT : (1 << IW);
   localparam int AW        = MEM_DEPTH > 1 ? $clog2(MEM_DEPTH) : 1;

   lif_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            lif_pkg::REG_VOLTAGE_DECAY: cfg_in.voltage_decay = csr_wdata[KW-1:0];
            lif_pkg::REG_PSP_GAIN:      cfg_in.psp_gain      = csr_wdata[KW-1:0];
            lif_pkg::REG_PSP_DECAY:     cfg_in.psp_decay     = csr_wdata[KW-1:0];
            lif_pkg::REG_RESET_VOLTAGE: cfg_in.reset_voltage = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.voltage_decay <= lif_pkg::VOLTAGE_DECAY_RST;
         cfg_ff.psp_gain      <= lif_pkg::PSP_GAIN_RST;
         cfg_ff.psp_decay     <= lif_pkg::PSP_DECAY_RST;
         cfg_ff.reset_voltage <= lif_pkg::RESET_VOLTAGE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   logic [IW-1:0] req_idx;
   logic [DW-1:0] req_cur;
   logic          req_bank;
   logic          hazard;
   logic          pipe_ready;
   logic          accept;

   lif_pkg::stage_tag_type [lif_pkg::PIPE_STAGES-1:0] tags;
   lif_pkg::wb_type                                   wb;

   assign req_idx  = req_tdata[IW-1:0];
   assign req_cur  = req_tdata[IW+DW-1:IW];
   assign req_bank = int'(req_idx) < NEURON_COUNT;

   // same neuron still in flight: its state is not yet written back
   always_comb begin
      hazard = 1'b0;
      for (int k = 0; k < lif_pkg::PIPE_STAGES; k++) begin
         if (tags[k].valid && tags[k].idx == req_idx) hazard = 1'b1;
      end
   end

   assign req_tready = pipe_ready && !hazard;
   assign accept     = req_tvalid && req_tready;

   logic [MEM_DEPTH-1:0] entry_vld_ff, entry_vld_in;
   logic                 rd_vld_ff;
   logic [2*DW-1:0]      ram_rdata;
   logic [AW-1:0]        ram_raddr, ram_waddr;
   logic [DW-1:0]        old_psp, old_volt;

   assign ram_raddr = req_idx[AW-1:0];
   assign ram_waddr = wb.idx[AW-1:0];

   always_comb begin
      entry_vld_in = entry_vld_ff;
      if (wb.en) entry_vld_in[ram_waddr] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_vld_ff <= '0;
         rd_vld_ff    <= 1'b0;
      end else begin
         entry_vld_ff <= entry_vld_in;
         if (accept) rd_vld_ff <= entry_vld_ff[ram_raddr];
      end
   end

   lif_ram #(
      .WIDTH(2 * DW),
      .DEPTH(MEM_DEPTH)
   ) u_state_ram (
      .clock(clock),
      .we   (wb.en),
      .waddr(ram_waddr),
      .wdata({wb.volt, wb.psp}),
      .re   (accept),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   // never-written entries read as their reset values
   assign old_psp  = rd_vld_ff ? ram_rdata[DW-1:0]    : lif_pkg::PSP_RST;
   assign old_volt = rd_vld_ff ? ram_rdata[2*DW-1:DW] : lif_pkg::VOLT_RST;

   logic [IW-1:0] rsp_idx;
   logic          rsp_spiked;
   logic [DW-1:0] rsp_psp, rsp_volt;

   lif_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (accept),
      .in_idx    (req_idx),
      .in_bank   (req_bank),
      .in_cur    (req_cur),
      .in_ready  (pipe_ready),
      .old_psp   (old_psp),
      .old_volt  (old_volt),
      .tags      (tags),
      .wb        (wb),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_idx   (rsp_idx),
      .rsp_spiked(rsp_spiked),
      .rsp_psp   (rsp_psp),
      .rsp_volt  (rsp_volt)
   );

   assign rsp_tdata = {2'b00, rsp_volt, rsp_psp, rsp_spiked, rsp_idx};

   // a spike always leaves the refractory count behind
   a_spike_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[5] |-> rsp_tdata[69:38] == lif_pkg::REFRACTORY_TICKS)
      else $error("spike without refractory count");

   a_out_of_bank: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && int'(rsp_tdata[4:0]) >= NEURON_COUNT |-> rsp_tdata[69:5] == '0)
      else $error("out-of-bank result carries payload");

   a_wb_issues: assert property (@(posedge clock) disable iff (reset)
      wb.en |=> rsp_tvalid)
      else $error("state write-back without result");

   a_no_raw: assert property (@(posedge clock) disable iff (reset)
      accept |-> !(wb.en && wb.idx == req_idx))
      else $error("read of a neuron being written back");

endmodule
